// ===== design/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// Process state scheduler package
// Shared constants, types and command structures for the scheduler.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int NUM_PROCS = 20;
    localparam int TICK_BITS = 32;
    localparam int PID_W = $clog2(NUM_PROCS);
    localparam int CNT_W = $clog2(NUM_PROCS + 1);

    typedef logic [PID_W-1:0] pid_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [TICK_BITS-1:0] tick_t;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_NEW      = 3'd1,
        OP_SLEEP    = 3'd2,
        OP_LOCK     = 3'd3,
        OP_UNLOCK   = 3'd4,
        OP_DISPATCH = 3'd5,
        OP_GETPID   = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        PS_FREE     = 3'd0,
        PS_RUN      = 3'd1,
        PS_READY    = 3'd2,
        PS_SLEEPING = 3'd3,
        PS_WAIT     = 3'd4
    } pstate_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_NO_RUN   = 2'd2;
    localparam logic [1:0] ST_RQ_EMPTY = 2'd3;

    localparam logic [0:0] CFG_TIME_SLICE = 1'd0;
    localparam logic [0:0] CFG_TPSU       = 1'd1;

    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
        logic mul_load;
    } pss_cmd_t;

    typedef struct packed {
        logic scan_last;
    } pss_stat_t;

    typedef struct packed {
        logic [1:0] status;
        pid_t       result_pid;
        logic       running_valid;
        pid_t       running_pid;
        logic       preempted;
        cnt_t       woken_count;
        cnt_t       run_queue_count;
        logic       mutex_locked;
    } result_t;

endpackage

// ===== design/pss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Process state scheduler controller
// Sequences one event: start, a multiply step, a scan over all process entries, finish.
// ----------------------------------------------------------------------------
module pss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              out_busy,
    input  pss_pkg::pss_stat_t stat,
    output logic              busy,
    output pss_pkg::pss_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.start = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_load = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> state_reg == S_MUL)
        else $error("start did not enter multiply step");
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> !busy)
        else $error("finish did not return to idle");
`endif

endmodule

// ===== design/pss_datapath.sv =====
// ----------------------------------------------------------------------------
// Process state scheduler datapath
// Process table, pid FIFOs, mutex, tick counter and the running pid.
// ----------------------------------------------------------------------------
module pss_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pss_pkg::pss_cmd_t      cmd,
    output pss_pkg::pss_stat_t     stat,
    input  logic [2:0]             opcode,
    input  logic [15:0]            sleep_units,
    input  logic                   cfg_we,
    input  logic                   cfg_idx,
    input  logic [15:0]            cfg_data,
    output pss_pkg::result_t       res
);

    localparam int N = pss_pkg::NUM_PROCS;
    localparam int PW = pss_pkg::PID_W;
    localparam int CW = pss_pkg::CNT_W;
    localparam int TB = pss_pkg::TICK_BITS;

    logic [15:0] slice_reg, tpsu_reg;
    logic [2:0]  op_reg;
    logic [15:0] units_reg;
    logic [31:0] prod_reg;
    pss_pkg::pstate_t pst_reg [N];
    pss_pkg::tick_t   wake_reg [N];
    logic [15:0]      used_reg [N];
    pss_pkg::pid_t    ffifo_reg [N];
    pss_pkg::pid_t    rfifo_reg [N];
    pss_pkg::pid_t    wfifo_reg [N];
    pss_pkg::pid_t    fhead_reg, rhead_reg, whead_reg;
    pss_pkg::cnt_t    fcnt_reg, rcnt_reg, wcnt_reg;
    logic             lock_reg;
    pss_pkg::tick_t   tick_reg;
    pss_pkg::pid_t    cur_reg;
    logic             curv_reg;
    pss_pkg::pid_t    idx_reg;
    pss_pkg::cnt_t    woken_reg;
    logic [1:0]       status_reg;
    pss_pkg::pid_t    rpid_reg;
    logic             pre_reg;

    function automatic pss_pkg::pid_t wrap(input pss_pkg::cnt_t h, input pss_pkg::cnt_t c);
        logic [CW:0] s;
        s = {1'b0, h} + {1'b0, c};
        if (s >= (CW+1)'(N)) begin
            s = s - (CW+1)'(N);
        end
        return s[PW-1:0];
    endfunction

    function automatic pss_pkg::pid_t inc(input pss_pkg::pid_t h);
        return (h == PW'(N - 1)) ? '0 : h + 1'b1;
    endfunction

    assign stat.scan_last = (idx_reg == PW'(N - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reg <= 16'd10;
            tpsu_reg <= 16'd100;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == pss_pkg::CFG_TIME_SLICE) begin
                    slice_reg <= cfg_data;
                end else begin
                    tpsu_reg <= cfg_data;
                end
            end
            if (cmd.start) begin
                op_reg <= opcode;
                units_reg <= sleep_units;
            end
            if (cmd.mul_load) begin
                prod_reg <= tpsu_reg * units_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                pst_reg[i] <= pss_pkg::PS_FREE;
                wake_reg[i] <= '0;
                used_reg[i] <= '0;
                ffifo_reg[i] <= PW'(i);
                rfifo_reg[i] <= '0;
                wfifo_reg[i] <= '0;
            end
            fhead_reg <= '0; rhead_reg <= '0; whead_reg <= '0;
            fcnt_reg <= CW'(N); rcnt_reg <= '0; wcnt_reg <= '0;
            lock_reg <= 1'b0;
            tick_reg <= '0;
            cur_reg <= '0;
            curv_reg <= 1'b0;
            idx_reg <= '0;
            woken_reg <= '0;
            status_reg <= pss_pkg::ST_OK;
            rpid_reg <= '0;
            pre_reg <= 1'b0;
        end else if (cmd.start) begin
            idx_reg <= '0;
            woken_reg <= '0;
            status_reg <= pss_pkg::ST_OK;
            rpid_reg <= '0;
            pre_reg <= 1'b0;
            if (opcode == pss_pkg::OP_TICK) begin
                tick_reg <= tick_reg + 1'b1;
            end
        end else if (cmd.scan) begin
            idx_reg <= stat.scan_last ? idx_reg : idx_reg + 1'b1;
            if (op_reg == pss_pkg::OP_TICK && pst_reg[idx_reg] == pss_pkg::PS_SLEEPING
                && wake_reg[idx_reg] == tick_reg) begin
                pst_reg[idx_reg] <= pss_pkg::PS_READY;
                woken_reg <= woken_reg + 1'b1;
                if (rcnt_reg < CW'(N)) begin
                    rfifo_reg[wrap(CW'(rhead_reg), rcnt_reg)] <= idx_reg;
                    rcnt_reg <= rcnt_reg + 1'b1;
                end
            end
        end else if (cmd.finish) begin
            case (op_reg)
                pss_pkg::OP_TICK: begin
                    if (curv_reg && cur_reg != '0) begin
                        used_reg[cur_reg] <= used_reg[cur_reg] + 1'b1;
                        if (used_reg[cur_reg] + 16'd1 == slice_reg) begin
                            pst_reg[cur_reg] <= pss_pkg::PS_READY;
                            if (rcnt_reg < CW'(N)) begin
                                rfifo_reg[wrap(CW'(rhead_reg), rcnt_reg)] <= cur_reg;
                                rcnt_reg <= rcnt_reg + 1'b1;
                            end
                            curv_reg <= 1'b0;
                            pre_reg <= 1'b1;
                        end
                    end
                end
                pss_pkg::OP_NEW: begin
                    if (fcnt_reg == '0) begin
                        status_reg <= pss_pkg::ST_NO_FREE;
                    end else begin
                        fhead_reg <= inc(fhead_reg);
                        fcnt_reg <= fcnt_reg - 1'b1;
                        pst_reg[ffifo_reg[fhead_reg]] <= pss_pkg::PS_RUN;
                        wake_reg[ffifo_reg[fhead_reg]] <= '0;
                        used_reg[ffifo_reg[fhead_reg]] <= '0;
                        rpid_reg <= ffifo_reg[fhead_reg];
                        if (ffifo_reg[fhead_reg] != '0 && rcnt_reg < CW'(N)) begin
                            rfifo_reg[wrap(CW'(rhead_reg), rcnt_reg)] <= ffifo_reg[fhead_reg];
                            rcnt_reg <= rcnt_reg + 1'b1;
                        end
                    end
                end
                pss_pkg::OP_SLEEP: begin
                    if (!curv_reg) begin
                        status_reg <= pss_pkg::ST_NO_RUN;
                    end else begin
                        wake_reg[cur_reg] <= tick_reg + TB'(prod_reg);
                        pst_reg[cur_reg] <= pss_pkg::PS_SLEEPING;
                        curv_reg <= 1'b0;
                    end
                end
                pss_pkg::OP_LOCK: begin
                    if (!curv_reg) begin
                        status_reg <= pss_pkg::ST_NO_RUN;
                    end else if (!lock_reg) begin
                        lock_reg <= 1'b1;
                    end else begin
                        if (wcnt_reg < CW'(N)) begin
                            wfifo_reg[wrap(CW'(whead_reg), wcnt_reg)] <= cur_reg;
                            wcnt_reg <= wcnt_reg + 1'b1;
                        end
                        pst_reg[cur_reg] <= pss_pkg::PS_WAIT;
                        curv_reg <= 1'b0;
                    end
                end
                pss_pkg::OP_UNLOCK: begin
                    if (wcnt_reg == '0) begin
                        lock_reg <= 1'b0;
                    end else begin
                        whead_reg <= inc(whead_reg);
                        wcnt_reg <= wcnt_reg - 1'b1;
                        pst_reg[wfifo_reg[whead_reg]] <= pss_pkg::PS_RUN;
                        if (rcnt_reg < CW'(N)) begin
                            rfifo_reg[wrap(CW'(rhead_reg), rcnt_reg)] <= wfifo_reg[whead_reg];
                            rcnt_reg <= rcnt_reg + 1'b1;
                        end
                    end
                end
                pss_pkg::OP_DISPATCH: begin
                    if (curv_reg && cur_reg != '0) begin
                        rpid_reg <= cur_reg;
                    end else if (rcnt_reg == '0) begin
                        status_reg <= pss_pkg::ST_RQ_EMPTY;
                    end else begin
                        rhead_reg <= inc(rhead_reg);
                        rcnt_reg <= rcnt_reg - 1'b1;
                        pst_reg[rfifo_reg[rhead_reg]] <= pss_pkg::PS_RUN;
                        used_reg[rfifo_reg[rhead_reg]] <= '0;
                        cur_reg <= rfifo_reg[rhead_reg];
                        curv_reg <= 1'b1;
                        rpid_reg <= rfifo_reg[rhead_reg];
                    end
                end
                pss_pkg::OP_GETPID: begin
                    if (!curv_reg) begin
                        status_reg <= pss_pkg::ST_NO_RUN;
                    end else begin
                        rpid_reg <= cur_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res.status = status_reg;
        res.result_pid = rpid_reg;
        res.running_valid = curv_reg;
        res.running_pid = curv_reg ? cur_reg : '0;
        res.preempted = pre_reg;
        res.woken_count = woken_reg;
        res.run_queue_count = rcnt_reg;
        res.mutex_locked = lock_reg;
    end

`ifndef SYNTHESIS
    a_rcnt: assert property (@(posedge aclk) disable iff (!aresetn) rcnt_reg <= CW'(N))
        else $error("run queue count overflow");
    a_fcnt: assert property (@(posedge aclk) disable iff (!aresetn) fcnt_reg <= CW'(N))
        else $error("free queue count overflow");
    a_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> woken_reg == '0)
        else $error("woken count not cleared at start");
`endif

endmodule

// ===== design/process_state_scheduler_top.sv =====
// An event passes through the start, multiply, scan and finish steps, then finish_d_reg and the output register.
// A new event is accepted only while the controller is idle, so one event at a time.
// The scan visits one process entry per cycle through a single compare unit.
// A new event is accepted while the previous result beat waits on the output register.
// Reset is synchronous, active low: all pids free, run and wait queues empty, tick counter zero.
// ----------------------------------------------------------------------------
// Process state scheduler top level
// Streaming event input, one result beat per event, plain configuration port.
// ----------------------------------------------------------------------------
module process_state_scheduler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[2:0], sleep_units[18:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status, result_pid, running_valid, running_pid,
                                   // preempted, woken_count, run_queue_count, mutex_locked
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    pss_pkg::pss_cmd_t  cmd;
    pss_pkg::pss_stat_t stat;
    pss_pkg::result_t   res;
    logic busy;
    logic in_fire;
    logic mvalid_reg;
    logic [31:0] mdata_reg;

    assign s_tready = !busy;
    assign in_fire = s_tvalid && s_tready;

    pss_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(mvalid_reg && !m_tready), .stat(stat), .busy(busy), .cmd(cmd)
    );

    pss_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .opcode(s_tdata[2:0]), .sleep_units(s_tdata[18:3]),
        .cfg_we(cfg_we), .cfg_idx(cfg_addr), .cfg_data(cfg_wdata), .res(res)
    );

    logic finish_d_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finish_d_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            finish_d_reg <= cmd.finish;
            if (finish_d_reg) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
        if (finish_d_reg) begin
            mdata_reg <= {7'd0, res.mutex_locked, res.run_queue_count, res.woken_count,
                          res.preempted, res.running_pid, res.running_valid,
                          res.result_pid, res.status};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;

endmodule
